>>> hdl/smic_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smic_pkg: shared types and constants of the stack machine integer core
// Action codes, status codes and field widths.
// ----------------------------------------------------------------------------
package smic_pkg;

	localparam int unsigned DataW  = 32;
	localparam int unsigned DepthW = 10;

	typedef enum logic [4:0] {
		ACT_PUSH   = 5'd0,
		ACT_DROP   = 5'd1,
		ACT_DUP    = 5'd2,
		ACT_SWAP   = 5'd3,
		ACT_OVER   = 5'd4,
		ACT_ROT    = 5'd5,
		ACT_ADD    = 5'd6,
		ACT_SUB    = 5'd7,
		ACT_MUL    = 5'd8,
		ACT_DIV    = 5'd9,
		ACT_MOD    = 5'd10,
		ACT_LT     = 5'd11,
		ACT_LE     = 5'd12,
		ACT_GT     = 5'd13,
		ACT_GE     = 5'd14,
		ACT_EQ     = 5'd15,
		ACT_NE     = 5'd16,
		ACT_AND    = 5'd17,
		ACT_OR     = 5'd18,
		ACT_NOT    = 5'd19,
		ACT_ASSERT = 5'd20,
		ACT_NOP    = 5'd21
	} action_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_UNDER  = 2'd1,
		ST_OVER   = 2'd2,
		ST_ASSERT = 2'd3
	} status_t;

endpackage

`default_nettype wire

>>> hdl/smic_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smic_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smic_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> hdl/smic_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smic_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smic_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [31:0]      quotient,
	output logic [31:0]      remainder
);

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	// one restoring step
	always_comb begin
		shifted = {rem_q, quo_q[31]};
		diff    = shifted - {1'b0, dvs_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

>>> hdl/smic_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smic_alu: shared arithmetic, compare and logic unit
// Add, subtract, low word multiply, signed compares and boolean ops.
// ----------------------------------------------------------------------------
module smic_alu (
	input  wire smic_pkg::action_t op,
	input  wire logic [31:0]       lhs,
	input  wire logic [31:0]       rhs,
	output logic      [31:0]       result
);

	logic signed [31:0] ls;
	logic signed [31:0] rs;
	logic [31:0]        prod;

	assign ls   = lhs;
	assign rs   = rhs;
	// only the low word of the product is kept
	assign prod = lhs * rhs;

	always_comb begin
		case (op)
			smic_pkg::ACT_ADD: result = lhs + rhs;
			smic_pkg::ACT_SUB: result = lhs - rhs;
			smic_pkg::ACT_MUL: result = prod;
			smic_pkg::ACT_LT:  result = {31'd0, ls < rs};
			smic_pkg::ACT_LE:  result = {31'd0, ls <= rs};
			smic_pkg::ACT_GT:  result = {31'd0, ls > rs};
			smic_pkg::ACT_GE:  result = {31'd0, ls >= rs};
			smic_pkg::ACT_EQ:  result = {31'd0, lhs == rhs};
			smic_pkg::ACT_NE:  result = {31'd0, lhs != rhs};
			smic_pkg::ACT_AND: result = {31'd0, (lhs != 32'd0) && (rhs != 32'd0)};
			smic_pkg::ACT_OR:  result = {31'd0, (lhs != 32'd0) || (rhs != 32'd0)};
			default:           result = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/stack_machine_integer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stack_machine_integer_core: integer data stack with its ALU
// An accepted input beat moves through the read and execute states to the result
// beat; div and mod with a nonzero divisor also wait in the divider state for the
// iterative divider. One item at a time: no new input is taken until the result
// beat has been taken.
// Reset clears the depth to zero; stack RAM contents are not cleared.
// ----------------------------------------------------------------------------
module stack_machine_integer_core #(
	parameter int unsigned STACK_CAPACITY = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [4:0]          action,
	input  wire logic signed [31:0]  literal,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [31:0]       top_value,
	output logic signed [31:0]       next_value,
	output logic [9:0]               depth,
	output logic [1:0]               status
);

	localparam int unsigned CW = $clog2(STACK_CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_DIV,
		S_EXEC,
		S_OUT
	} state_t;

	state_t            state_q;
	smic_pkg::action_t act_q;
	logic [31:0]       lit_q;
	logic [31:0]       top_q;
	logic [31:0]       next_q;
	logic [CW-1:0]     count_q;
	smic_pkg::status_t status_q;

	logic [1:0]  needed;
	logic        grows;
	logic        under;
	logic        over;
	logic        is_div;
	logic [31:0] alu_res;
	logic [31:0] rdata;
	logic        ram_we;
	logic [CW-1:0] ram_waddr;
	logic [CW-1:0] ram_raddr;
	logic        div_start;
	logic        div_done;
	logic [31:0] div_quo;
	logic [31:0] div_rem;
	logic [31:0] l_mag;
	logic [31:0] r_mag;
	logic [31:0] q_signed;
	logic [31:0] r_signed;
	logic        cnt_ge2;

	// operand requirements of the held action
	always_comb begin
		case (act_q)
			smic_pkg::ACT_DROP, smic_pkg::ACT_DUP,
			smic_pkg::ACT_NOT, smic_pkg::ACT_ASSERT: needed = 2'd1;
			smic_pkg::ACT_ROT:                       needed = 2'd3;
			smic_pkg::ACT_SWAP, smic_pkg::ACT_OVER, smic_pkg::ACT_ADD,
			smic_pkg::ACT_SUB, smic_pkg::ACT_MUL, smic_pkg::ACT_DIV,
			smic_pkg::ACT_MOD, smic_pkg::ACT_LT, smic_pkg::ACT_LE,
			smic_pkg::ACT_GT, smic_pkg::ACT_GE, smic_pkg::ACT_EQ,
			smic_pkg::ACT_NE, smic_pkg::ACT_AND, smic_pkg::ACT_OR:
			                                         needed = 2'd2;
			default:                                 needed = 2'd0;
		endcase
	end

	assign grows   = (act_q == smic_pkg::ACT_PUSH) || (act_q == smic_pkg::ACT_DUP) ||
	                 (act_q == smic_pkg::ACT_OVER);
	assign under   = ((CW+1)'(count_q) < (CW+1)'(needed));
	assign over    = !under && grows &&
	                 (({1'b0, count_q} + (CW+1)'(1)) >= (CW+1)'(STACK_CAPACITY));
	assign is_div  = (act_q == smic_pkg::ACT_DIV) || (act_q == smic_pkg::ACT_MOD);
	assign cnt_ge2 = (CW+1)'(count_q) >= (CW+1)'(2);

	// shared ALU
	smic_alu u_alu (
		.op     (act_q),
		.lhs    (next_q),
		.rhs    (top_q),
		.result (alu_res)
	);

	// signed division through the unsigned iterative divider
	assign l_mag     = next_q[31] ? (32'd0 - next_q) : next_q;
	assign r_mag     = top_q[31] ? (32'd0 - top_q) : top_q;
	assign q_signed  = (next_q[31] ^ top_q[31]) ? (32'd0 - div_quo) : div_quo;
	assign r_signed  = next_q[31] ? (32'd0 - div_rem) : div_rem;
	assign div_start = (state_q == S_READ) && is_div && !under && (top_q != 32'd0);

	smic_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (l_mag),
		.divisor   (r_mag),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// stack RAM holds every item below the two cached top items
	assign ram_raddr = count_q - CW'(3);
	assign ram_waddr = (act_q == smic_pkg::ACT_ROT) ? (count_q - CW'(3)) : (count_q - CW'(2));
	always_comb begin
		ram_we = 1'b0;
		if (state_q == S_EXEC && !under && !over) begin
			case (act_q)
				smic_pkg::ACT_PUSH, smic_pkg::ACT_DUP,
				smic_pkg::ACT_OVER: ram_we = cnt_ge2;
				smic_pkg::ACT_ROT:  ram_we = 1'b1;
				default:            ram_we = 1'b0;
			endcase
		end
	end

	smic_ram #(
		.WIDTH (32),
		.DEPTH (STACK_CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (next_q),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	// sequencer, cached top items and depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			status_q <= smic_pkg::ST_OK;
			act_q    <= smic_pkg::ACT_NOP;
			lit_q    <= '0;
			top_q    <= '0;
			next_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q   <= smic_pkg::action_t'(action);
						lit_q   <= literal;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= div_start ? S_DIV : S_EXEC;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q  <= S_OUT;
					status_q <= smic_pkg::ST_OK;
					if (under) begin
						status_q <= smic_pkg::ST_UNDER;
					end else if (over) begin
						status_q <= smic_pkg::ST_OVER;
					end else begin
						case (act_q)
							smic_pkg::ACT_PUSH: begin
								top_q   <= lit_q;
								next_q  <= top_q;
								count_q <= count_q + CW'(1);
							end
							smic_pkg::ACT_DUP: begin
								next_q  <= top_q;
								count_q <= count_q + CW'(1);
							end
							smic_pkg::ACT_OVER: begin
								top_q   <= next_q;
								next_q  <= top_q;
								count_q <= count_q + CW'(1);
							end
							smic_pkg::ACT_DROP: begin
								top_q   <= next_q;
								next_q  <= rdata;
								count_q <= count_q - CW'(1);
							end
							smic_pkg::ACT_ASSERT: begin
								top_q   <= next_q;
								next_q  <= rdata;
								count_q <= count_q - CW'(1);
								if (top_q == 32'd0) begin
									status_q <= smic_pkg::ST_ASSERT;
								end
							end
							smic_pkg::ACT_SWAP: begin
								top_q  <= next_q;
								next_q <= top_q;
							end
							smic_pkg::ACT_ROT: begin
								top_q  <= rdata;
								next_q <= top_q;
							end
							smic_pkg::ACT_DIV, smic_pkg::ACT_MOD: begin
								if (top_q == 32'd0) begin
									next_q <= '0;
									top_q  <= '0;
								end else begin
									next_q <= (act_q == smic_pkg::ACT_DIV) ? q_signed : r_signed;
									top_q  <= 32'd1;
								end
							end
							smic_pkg::ACT_NOT: begin
								top_q <= {31'd0, top_q == 32'd0};
							end
							smic_pkg::ACT_ADD, smic_pkg::ACT_SUB, smic_pkg::ACT_MUL,
							smic_pkg::ACT_LT, smic_pkg::ACT_LE, smic_pkg::ACT_GT,
							smic_pkg::ACT_GE, smic_pkg::ACT_EQ, smic_pkg::ACT_NE,
							smic_pkg::ACT_AND, smic_pkg::ACT_OR: begin
								top_q   <= alu_res;
								next_q  <= rdata;
								count_q <= count_q - CW'(1);
							end
							default: begin
							end
						endcase
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result beat
	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = (state_q == S_OUT);
	assign top_value  = (count_q != '0) ? top_q : 32'd0;
	assign next_value = cnt_ge2 ? next_q : 32'd0;
	assign depth      = smic_pkg::DepthW'(count_q);
	assign status     = status_q;

	// checks
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result is pending");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		((CW+1)'(count_q) < (CW+1)'(STACK_CAPACITY)))
		else $error("stack depth beyond capacity");
	a_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status_q == smic_pkg::ST_OVER) |->
		(({1'b0, count_q} + (CW+1)'(1)) == (CW+1)'(STACK_CAPACITY)))
		else $error("overflow reported below capacity");
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside its wait state");

endmodule

`default_nettype wire

>>> tb/sv/stack_machine_integer_core_tb.sv
// ----------------------------------------------------------------------------
// stack_machine_integer_core_tb: self-checking bench for the integer stack core
// Drives action/literal beats from a queue, predicts each result beat with a
// behavioral stack model, and compares every output beat field by field.
// ----------------------------------------------------------------------------
module stack_machine_integer_core_tb;

	localparam int Capacity = 1024;

	typedef struct packed {
		logic [4:0]  act;
		logic [31:0] lit;
	} op_beat_t;

	typedef struct packed {
		logic [31:0] top;
		logic [31:0] nxt;
		logic [9:0]  dep;
		logic [1:0]  st;
	} stack_view_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [4:0] action = '0;
	logic signed [31:0] literal = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] top_value, next_value;
	logic [9:0] depth;
	logic [1:0] status;

	stack_machine_integer_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .literal(literal),
		.out_valid(out_valid), .out_stall(out_stall),
		.top_value(top_value), .next_value(next_value),
		.depth(depth), .status(status)
	);

	always #1 clk = ~clk;

	// model state
	logic [31:0] model_mem [Capacity];
	int unsigned model_cnt = 0;
	// planner depth, tracks stack size while stimulus is generated
	int unsigned plan_cnt = 0;

	op_beat_t pending_ops[$];
	stack_view_t expected_views[$];
	int errors = 0;
	bit stim_done = 0;
	bit long_hold = 0;

	// acceptance flag from the last rising edge, and the accepted count
	logic taken_s = 1'b0;
	int sent = 0;

	task automatic report(input string what);
		errors++;
		$display("mismatch: %s", what);
	endtask

	function automatic logic [31:0] model_item(input int unsigned k);
		return (k < model_cnt) ? model_mem[model_cnt - 1 - k] : 32'd0;
	endfunction

	function automatic int unsigned needs_of(input logic [4:0] a);
		case (a)
			smic_pkg::ACT_DROP, smic_pkg::ACT_DUP,
			smic_pkg::ACT_NOT, smic_pkg::ACT_ASSERT: return 1;
			smic_pkg::ACT_ROT: return 3;
			smic_pkg::ACT_PUSH, smic_pkg::ACT_NOP: return 0;
			default: return (a <= smic_pkg::ACT_OR) ? 2 : 0;
		endcase
	endfunction

	// apply one op to the model stack and return the expected view
	function automatic stack_view_t model_apply(input op_beat_t b);
		stack_view_t v;
		logic [31:0] r, l, t, res;
		logic signed [31:0] rs, ls;
		int unsigned n;
		logic [1:0] st;
		st = smic_pkg::ST_OK;
		n = model_cnt;
		r = model_item(0);
		l = model_item(1);
		rs = r;
		ls = l;
		if (n < needs_of(b.act)) begin
			st = smic_pkg::ST_UNDER;
		end else if ((b.act == smic_pkg::ACT_PUSH || b.act == smic_pkg::ACT_DUP ||
				b.act == smic_pkg::ACT_OVER) && n + 1 >= Capacity) begin
			st = smic_pkg::ST_OVER;
		end else begin
			case (b.act)
				smic_pkg::ACT_PUSH: begin model_mem[n] = b.lit; model_cnt = n + 1; end
				smic_pkg::ACT_DROP: model_cnt = n - 1;
				smic_pkg::ACT_DUP: begin model_mem[n] = r; model_cnt = n + 1; end
				smic_pkg::ACT_SWAP: begin model_mem[n-1] = l; model_mem[n-2] = r; end
				smic_pkg::ACT_OVER: begin model_mem[n] = l; model_cnt = n + 1; end
				smic_pkg::ACT_ROT: begin
					t = model_mem[n-3];
					model_mem[n-3] = l;
					model_mem[n-2] = r;
					model_mem[n-1] = t;
				end
				smic_pkg::ACT_DIV, smic_pkg::ACT_MOD: begin
					if (r == 0) begin
						model_mem[n-2] = 0;
						model_mem[n-1] = 0;
					end else begin
						// INT_MIN / -1 wraps; remainder 0
						if (ls == 32'sh80000000 && rs == -1)
							res = (b.act == smic_pkg::ACT_DIV) ? 32'h80000000 : 32'd0;
						else
							res = (b.act == smic_pkg::ACT_DIV) ? ls / rs : ls % rs;
						model_mem[n-2] = res;
						model_mem[n-1] = 32'd1;
					end
				end
				smic_pkg::ACT_NOT: model_mem[n-1] = (r == 0) ? 32'd1 : 32'd0;
				smic_pkg::ACT_ASSERT: begin
					model_cnt = n - 1;
					if (r == 0) st = smic_pkg::ST_ASSERT;
				end
				default: begin
					if (b.act >= smic_pkg::ACT_ADD && b.act <= smic_pkg::ACT_OR) begin
						case (b.act)
							smic_pkg::ACT_ADD: res = l + r;
							smic_pkg::ACT_SUB: res = l - r;
							smic_pkg::ACT_MUL: res = l * r;
							smic_pkg::ACT_LT: res = ls < rs;
							smic_pkg::ACT_LE: res = ls <= rs;
							smic_pkg::ACT_GT: res = ls > rs;
							smic_pkg::ACT_GE: res = ls >= rs;
							smic_pkg::ACT_EQ: res = ls == rs;
							smic_pkg::ACT_NE: res = ls != rs;
							smic_pkg::ACT_AND: res = (l != 0) && (r != 0);
							default: res = (l != 0) || (r != 0);
						endcase
						model_mem[n-2] = res;
						model_cnt = n - 1;
					end
				end
			endcase
		end
		v.top = model_item(0);
		v.nxt = model_item(1);
		v.dep = model_cnt[9:0];
		v.st = st;
		return v;
	endfunction

	// queue an op and track depth for stimulus planning
	task automatic plan(input logic [4:0] a, input logic [31:0] lit);
		op_beat_t b;
		int unsigned need;
		b.act = a;
		b.lit = lit;
		pending_ops.push_back(b);
		need = needs_of(a);
		if (plan_cnt < need) return;
		case (a)
			smic_pkg::ACT_PUSH, smic_pkg::ACT_DUP, smic_pkg::ACT_OVER:
				if (plan_cnt + 1 < Capacity) plan_cnt++;
			smic_pkg::ACT_DROP, smic_pkg::ACT_ASSERT: plan_cnt--;
			default: if (a >= smic_pkg::ACT_ADD && a <= smic_pkg::ACT_OR &&
					a != smic_pkg::ACT_DIV && a != smic_pkg::ACT_MOD)
				plan_cnt--;
		endcase
	endtask

	function automatic logic [31:0] rand_lit();
		case ($urandom_range(0, 5))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'hffffffff;
			3: return $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	// stimulus
	initial begin
		logic [4:0] a;
		// directed: underflow cases on an empty stack
		plan(smic_pkg::ACT_DROP, 0);
		plan(smic_pkg::ACT_DUP, 0);
		plan(smic_pkg::ACT_ROT, 0);
		plan(smic_pkg::ACT_ADD, 0);
		// unknown action code acts as nop
		plan(5'd31, 32'hffffffff);
		plan(smic_pkg::ACT_PUSH, 32'h80000000);
		plan(smic_pkg::ACT_PUSH, 32'hffffffff);
		plan(smic_pkg::ACT_DIV, 0);
		plan(smic_pkg::ACT_PUSH, 32'h80000000);
		plan(smic_pkg::ACT_PUSH, 32'hffffffff);
		plan(smic_pkg::ACT_MOD, 0);
		plan(smic_pkg::ACT_PUSH, 32'h7fffffff);
		plan(smic_pkg::ACT_PUSH, 0);
		plan(smic_pkg::ACT_DIV, 0);
		plan(smic_pkg::ACT_ROT, 0);
		plan(smic_pkg::ACT_OVER, 0);
		plan(smic_pkg::ACT_SWAP, 0);
		plan(smic_pkg::ACT_NOT, 0);
		plan(smic_pkg::ACT_ASSERT, 0);
		plan(smic_pkg::ACT_PUSH, 0);
		plan(smic_pkg::ACT_ASSERT, 0);
		plan(smic_pkg::ACT_NOP, 0);
		// random phase, biased to keep a few items on the stack
		for (int i = 0; i < 400; i++) begin
			if (plan_cnt < 3 && $urandom_range(0, 3) != 0)
				a = smic_pkg::ACT_PUSH;
			else
				a = 5'($urandom_range(0, 31));
			plan(a, rand_lit());
		end
		// fill to the largest depth, one below capacity, overflow on push/dup/over, then drain partly
		while (plan_cnt < Capacity - 1) plan(smic_pkg::ACT_PUSH, $urandom);
		plan(smic_pkg::ACT_PUSH, 1);
		plan(smic_pkg::ACT_DUP, 0);
		plan(smic_pkg::ACT_OVER, 0);
		for (int i = 0; i < 20; i++) plan(5'($urandom_range(6, 18)), 0);
		stim_done = 1;
	end

	// sender: bursts and gaps
	int gap_left = 0, burst_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || taken_s) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					op_beat_t b;
					b = pending_ops.pop_front();
					action <= b.act;
					literal <= b.lit;
					in_valid <= 1'b1;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// acceptance sampled at rising edge; prediction happens here
	always @(posedge clk) begin
		taken_s <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			op_beat_t b;
			b.act = action;
			b.lit = literal;
			expected_views.push_back(model_apply(b));
			sent++;
		end
	end

	// receiver stall pattern, with one long hold-off
	int cyc = 0;
	int hold_left = 0;
	always @(negedge clk) begin
		cyc <= cyc + 1;
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (!long_hold && sent > 200) begin
			long_hold <= 1'b1;
			hold_left <= 400;
			out_stall <= 1'b1;
		end else if ((cyc / 300) % 3 == 0) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_views.size() == 0) begin
				report("result beat with no pending expectation");
			end else begin
				stack_view_t e;
				e = expected_views.pop_front();
				if (top_value !== e.top)
					report($sformatf("top_value %h exp %h", top_value, e.top));
				if (next_value !== e.nxt)
					report($sformatf("next_value %h exp %h", next_value, e.nxt));
				if (depth !== e.dep)
					report($sformatf("depth %0d exp %0d", depth, e.dep));
				if (status !== e.st)
					report($sformatf("status %0d exp %0d", status, e.st));
			end
		end
	end

	// reset, then wait for drain
	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (stim_done && pending_ops.size() == 0 && !in_valid);
		wait (expected_views.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_views.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
